// File: hw/rtl/urmf_pkg.sv
// Shared types, constants and filter microcode for the ultrasonic ranger.
// No dependencies; imported by urmf_out_if, the filter and the top level.
package urmf_pkg;

  localparam int unsigned SAMPLES_WANTED = 5;
  localparam int unsigned TICK_W         = 16;
  localparam int unsigned CNT_W          = 3;
  localparam int unsigned IDX_W          = 3;
  localparam int unsigned DIST_W         = 17;
  localparam int unsigned LOW_W          = 8;
  localparam int unsigned RANGE_W        = 10;
  localparam int unsigned APB_ADDR_W     = 5;
  localparam int unsigned APB_DATA_W     = 32;

  localparam logic [CNT_W-1:0] MIN_SAMPLES = 3'd3;

  // distance = x / D with x = width sum * 17; reciprocal estimate plus one fix-up
  localparam int unsigned SCALED_W    = 22;
  localparam int unsigned RECIP_W     = 19;
  localparam int unsigned RECIP_SHIFT = 22;
  localparam logic [RECIP_W-1:0] RECIP_DIV_MEAN   = 19'd139810;
  localparam logic [RECIP_W-1:0] RECIP_DIV_SINGLE = 19'd419430;
  localparam logic [4:0]         DIV_MEAN         = 5'd30;
  localparam logic [4:0]         DIV_SINGLE       = 5'd10;

  localparam logic [0:0]          RST_ENABLE        = 1'b0;
  localparam logic [LOW_W-1:0]    RST_TRIG_LOW      = 8'd2;
  localparam logic [LOW_W-1:0]    RST_TRIG_HIGH     = 8'd15;
  localparam logic [TICK_W-1:0]   RST_ECHO_TIMEOUT  = 16'd30000;
  localparam logic [TICK_W-1:0]   RST_GAP           = 16'd10000;
  localparam logic [RANGE_W-1:0]  RST_MAX_RANGE     = 10'd500;

  typedef enum logic [2:0] {
    REG_ENABLE       = 3'd0,
    REG_TRIG_LOW     = 3'd1,
    REG_TRIG_HIGH    = 3'd2,
    REG_ECHO_TIMEOUT = 3'd3,
    REG_GAP          = 3'd4,
    REG_MAX_RANGE    = 3'd5
  } urmf_reg_e;

  typedef enum logic [2:0] {
    OP_NOP       = 3'd0,
    OP_CHECK     = 3'd1,
    OP_SORT_EVEN = 3'd2,
    OP_SORT_ODD  = 3'd3,
    OP_SCALE     = 3'd4,
    OP_RECIP     = 3'd5,
    OP_FIX       = 3'd6
  } urmf_op_e;

  localparam int unsigned STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_HALT = 4'd9;

  typedef struct packed {
    urmf_op_e          op;
    logic              jmp_few;
    logic [STEP_W-1:0] target;
    logic              last;
  } urmf_uword_t;

  typedef struct packed {
    logic              start;
    logic [CNT_W-1:0]  count;
    logic              we;
    logic [IDX_W-1:0]  idx;
    logic [TICK_W-1:0] data;
  } urmf_flt_req_t;

  typedef struct packed {
    logic              busy;
    logic              status;
    logic [DIST_W-1:0] distance;
  } urmf_flt_rsp_t;

  // check, five rounds of odd-even transposition, scale, reciprocal, fix-up, halt
  function automatic urmf_uword_t urmf_ucode(input logic [STEP_W-1:0] step);
    urmf_uword_t w;
    w = '{op: OP_NOP, jmp_few: 1'b0, target: '0, last: 1'b0};
    unique case (step)
      4'd0:    w = '{op: OP_CHECK,     jmp_few: 1'b1, target: STEP_HALT, last: 1'b0};
      4'd1:    w.op = OP_SORT_EVEN;
      4'd2:    w.op = OP_SORT_ODD;
      4'd3:    w.op = OP_SORT_EVEN;
      4'd4:    w.op = OP_SORT_ODD;
      4'd5:    w.op = OP_SORT_EVEN;
      4'd6:    w.op = OP_SCALE;
      4'd7:    w.op = OP_RECIP;
      4'd8:    w.op = OP_FIX;
      default: w.last = 1'b1;
    endcase
    return w;
  endfunction

endpackage

// File: hw/rtl/urmf_if.sv
// Valid/ready channels for tick requests and result requests.
// Depends on urmf_pkg for field widths.
interface urmf_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic echo;

  modport source (output valid, start_req, echo, input ready);
  modport sink   (input valid, start_req, echo, output ready);
endinterface

interface urmf_out_if;
  import urmf_pkg::*;
  logic              valid;
  logic              ready;
  logic              trigger;
  logic              busy_res;
  logic              done_res;
  logic              status;
  logic [DIST_W-1:0] distance;
  logic [CNT_W-1:0]  valid_samples;

  modport source (output valid, trigger, busy_res, done_res, status, distance, valid_samples,
                  input ready);
  modport sink   (input valid, trigger, busy_res, done_res, status, distance, valid_samples,
                  output ready);
endinterface

// File: hw/rtl/urmf_filter.sv
// Sample store and microcoded median/mean filter datapath.
// Depends on urmf_pkg (control word table, request structs).
module urmf_filter (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  urmf_pkg::urmf_flt_req_t req_i,
  output urmf_pkg::urmf_flt_rsp_t rsp_o
);
  import urmf_pkg::*;

  logic [TICK_W-1:0]         smp_q [SAMPLES_WANTED];
  logic [TICK_W-1:0]         smp_d [SAMPLES_WANTED];
  logic                      active_q;
  logic [STEP_W-1:0]         step_q;
  logic [CNT_W-1:0]          n_q;
  logic                      status_q;
  logic [DIST_W-1:0]         dist_q;
  logic [SCALED_W-1:0]       x_q;
  logic [DIST_W-1:0]         q0_q;
  urmf_uword_t               uw;
  logic                      few;
  logic                      five;
  logic                      odd;
  logic [TICK_W+1:0]         mean_sum;
  logic [TICK_W+1:0]         base;
  logic [SCALED_W-1:0]       x_d;
  logic [SCALED_W+RECIP_W-1:0] prod;
  logic [4:0]                divisor;
  logic [SCALED_W-1:0]       rem;
  logic [DIST_W-1:0]         q_fix;

  assign uw   = urmf_ucode(step_q);
  assign few  = n_q < MIN_SAMPLES;
  assign five = n_q == CNT_W'(SAMPLES_WANTED);
  assign odd  = uw.op == OP_SORT_ODD;

  always_comb begin
    smp_d = smp_q;
    if (req_i.we && (req_i.idx < IDX_W'(SAMPLES_WANTED))) begin
      smp_d[req_i.idx] = req_i.data;
    end
    if (active_q && (uw.op inside {OP_SORT_EVEN, OP_SORT_ODD})) begin
      for (int k = 0; k < int'(SAMPLES_WANTED) - 1; k++) begin
        if ((1'(k) == odd) && (CNT_W'(k + 1) < n_q) && (smp_q[k+1] < smp_q[k])) begin
          smp_d[k]   = smp_q[k+1];
          smp_d[k+1] = smp_q[k];
        end
      end
    end
  end

  // scale: pick the middle values, times 17
  assign mean_sum = (TICK_W+2)'(smp_q[1]) + (TICK_W+2)'(smp_q[2]) + (TICK_W+2)'(smp_q[3]);
  always_comb begin
    if (five) begin
      base = mean_sum;
    end else if (n_q == 3'd4) begin
      base = (TICK_W+2)'(smp_q[2]);
    end else begin
      base = (TICK_W+2)'(smp_q[1]);
    end
  end
  assign x_d = {base, 4'b0000} + SCALED_W'(base);

  assign prod    = (SCALED_W+RECIP_W)'(x_q) *
                   (SCALED_W+RECIP_W)'(five ? RECIP_DIV_MEAN : RECIP_DIV_SINGLE);
  assign divisor = five ? DIV_MEAN : DIV_SINGLE;
  assign rem     = x_q - SCALED_W'(q0_q) * SCALED_W'(divisor);
  assign q_fix   = (rem >= SCALED_W'(divisor)) ? q0_q + DIST_W'(1) : q0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      step_q   <= '0;
    end else if (req_i.start) begin
      active_q <= 1'b1;
      step_q   <= '0;
    end else if (active_q) begin
      if (uw.last) begin
        active_q <= 1'b0;
      end else if (uw.jmp_few && few) begin
        step_q <= uw.target;
      end else begin
        step_q <= step_q + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    smp_q <= smp_d;
    if (req_i.start) begin
      n_q <= req_i.count;
    end
    if (active_q) begin
      case (uw.op)
        OP_CHECK: begin
          status_q <= few;
          dist_q   <= '0;
        end
        OP_SCALE: x_q  <= x_d;
        OP_RECIP: q0_q <= prod[RECIP_SHIFT +: DIST_W];
        OP_FIX:   dist_q <= q_fix;
        default: ;
      endcase
    end
  end

  assign rsp_o.busy     = active_q;
  assign rsp_o.status   = status_q;
  assign rsp_o.distance = dist_q;

endmodule

// File: hw/rtl/ultrasonic_ranger_median_filter.sv
// Ultrasonic ranger top level: tick sequencer, config registers, result register.
// Depends on urmf_pkg, urmf_if (channels) and urmf_filter.
//
//   channel  | dir | payload                                            | handshake
//   in_i     | in  | start_req, echo                                    | valid/ready
//   out_o    | out | trigger, busy_res, done_res, status, distance,     | valid/ready
//            |     | valid_samples                                      |
//   apb      | in  | paddr, pwdata -> enable .. max_range_cm            | psel/penable
//
// One tick request per cycle while in_i.ready is high, one result request per tick.
// Entering the done phase runs the filter program, which goes from check to halt with
// fewer than three samples; in_i.ready is low while it runs.
// A one-entry result register lets the next tick in while the result drains.
// Reset: phase idle, counters zero, config at defaults.
module ultrasonic_ranger_median_filter #(
  parameter int unsigned MAX_TRIES = 8
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  urmf_in_if.sink                                 in_i,
  urmf_out_if.source                              out_o,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [urmf_pkg::APB_ADDR_W-1:0]         paddr,
  input  logic [urmf_pkg::APB_DATA_W-1:0]         pwdata,
  output logic [urmf_pkg::APB_DATA_W-1:0]         prdata,
  output logic                                    pready
);
  import urmf_pkg::*;

  localparam int unsigned TRY_W = $clog2(MAX_TRIES + 1);

  typedef enum logic [6:0] {
    PH_IDLE  = 7'b0000001,
    PH_TLOW  = 7'b0000010,
    PH_THIGH = 7'b0000100,
    PH_RISE  = 7'b0001000,
    PH_MEAS  = 7'b0010000,
    PH_GAP   = 7'b0100000,
    PH_DONE  = 7'b1000000
  } phase_e;

  logic                 enable_q;
  logic [LOW_W-1:0]     trig_low_q;
  logic [LOW_W-1:0]     trig_high_q;
  logic [TICK_W-1:0]    timeout_q;
  logic [TICK_W-1:0]    gap_q;
  logic [RANGE_W-1:0]   range_q;

  phase_e               phase_q, phase_d, try_phase;
  logic [TICK_W-1:0]    tick_q, tick_d;
  logic [TICK_W:0]      tick_inc;
  logic [TRY_W-1:0]     try_q, try_d, try_inc;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 width_ok;
  logic                 accept;
  logic                 cfg_wr;
  urmf_reg_e            reg_sel;

  urmf_flt_req_t        flt_req;
  urmf_flt_rsp_t        flt_rsp;

  logic                 out_valid_q;
  logic                 trig_q, busy_q, done_q, status_q;
  logic [DIST_W-1:0]    dist_q;
  logic [CNT_W-1:0]     vs_q;

  // config port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = urmf_reg_e'(paddr[APB_ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= RST_ENABLE;
      trig_low_q  <= RST_TRIG_LOW;
      trig_high_q <= RST_TRIG_HIGH;
      timeout_q   <= RST_ECHO_TIMEOUT;
      gap_q       <= RST_GAP;
      range_q     <= RST_MAX_RANGE;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_ENABLE:       enable_q    <= pwdata[0];
        REG_TRIG_LOW:     trig_low_q  <= pwdata[LOW_W-1:0];
        REG_TRIG_HIGH:    trig_high_q <= pwdata[LOW_W-1:0];
        REG_ECHO_TIMEOUT: timeout_q   <= pwdata[TICK_W-1:0];
        REG_GAP:          gap_q       <= pwdata[TICK_W-1:0];
        REG_MAX_RANGE:    range_q     <= pwdata[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_ENABLE:       prdata = APB_DATA_W'(enable_q);
      REG_TRIG_LOW:     prdata = APB_DATA_W'(trig_low_q);
      REG_TRIG_HIGH:    prdata = APB_DATA_W'(trig_high_q);
      REG_ECHO_TIMEOUT: prdata = APB_DATA_W'(timeout_q);
      REG_GAP:          prdata = APB_DATA_W'(gap_q);
      REG_MAX_RANGE:    prdata = APB_DATA_W'(range_q);
      default:          prdata = '0;
    endcase
  end

  // tick sequencer
  assign in_i.ready = !flt_rsp.busy && (!out_valid_q || out_o.ready);
  assign accept     = in_i.valid && in_i.ready;

  assign tick_inc  = {1'b0, tick_q} + (TICK_W+1)'(1);
  assign try_inc   = try_q + TRY_W'(1);
  assign try_phase = !enable_q ? PH_GAP : (trig_low_q == '0) ? PH_THIGH : PH_TLOW;
  assign width_ok  = (21'(tick_q) * 21'd17 <= 21'(range_q) * 21'd1000) &&
                     (cnt_q < CNT_W'(SAMPLES_WANTED));

  always_comb begin
    phase_d       = phase_q;
    tick_d        = tick_q;
    try_d         = try_q;
    cnt_d         = cnt_q;
    flt_req.start = 1'b0;
    flt_req.count = cnt_q;
    flt_req.we    = 1'b0;
    flt_req.idx   = cnt_q[IDX_W-1:0];
    flt_req.data  = tick_q;
    if (accept) begin
      unique case (phase_q)
        PH_IDLE: begin
          if (in_i.start_req) begin
            try_d   = '0;
            cnt_d   = '0;
            tick_d  = '0;
            phase_d = try_phase;
          end
        end
        PH_TLOW: begin
          if (tick_inc >= (TICK_W+1)'(trig_low_q)) begin
            phase_d = PH_THIGH;
            tick_d  = '0;
          end else begin
            tick_d = tick_inc[TICK_W-1:0];
          end
        end
        PH_THIGH: begin
          if (tick_inc >= (TICK_W+1)'(trig_high_q)) begin
            phase_d = PH_RISE;
            tick_d  = '0;
          end else begin
            tick_d = tick_inc[TICK_W-1:0];
          end
        end
        PH_RISE: begin
          if (in_i.echo) begin
            if (timeout_q <= TICK_W'(1)) begin
              phase_d = PH_GAP;
              tick_d  = '0;
            end else begin
              phase_d = PH_MEAS;
              tick_d  = TICK_W'(1);
            end
          end else if (tick_inc >= (TICK_W+1)'(timeout_q)) begin
            phase_d = PH_GAP;
            tick_d  = '0;
          end else begin
            tick_d = tick_inc[TICK_W-1:0];
          end
        end
        PH_MEAS: begin
          if (in_i.echo) begin
            if (tick_inc >= (TICK_W+1)'(timeout_q)) begin
              phase_d = PH_GAP;
              tick_d  = '0;
            end else begin
              tick_d = tick_inc[TICK_W-1:0];
            end
          end else begin
            flt_req.we = width_ok;
            if (width_ok) begin
              cnt_d = cnt_q + CNT_W'(1);
            end
            phase_d = PH_GAP;
            tick_d  = '0;
          end
        end
        PH_GAP: begin
          if (tick_inc >= (TICK_W+1)'(gap_q)) begin
            try_d = try_inc;
            if ((cnt_q >= CNT_W'(SAMPLES_WANTED)) || (try_inc >= TRY_W'(MAX_TRIES))) begin
              phase_d       = PH_DONE;
              tick_d        = tick_inc[TICK_W-1:0];
              flt_req.start = 1'b1;
            end else begin
              phase_d = try_phase;
              tick_d  = '0;
            end
          end else begin
            tick_d = tick_inc[TICK_W-1:0];
          end
        end
        default: begin
          phase_d = PH_IDLE;
          tick_d  = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      try_q   <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      try_q   <= try_d;
      cnt_q   <= cnt_d;
    end
  end

  urmf_filter u_filter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (flt_req),
    .rsp_o  (flt_rsp)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      trig_q   <= phase_q == PH_THIGH;
      busy_q   <= (phase_q != PH_IDLE) && (phase_q != PH_DONE);
      done_q   <= phase_q == PH_DONE;
      status_q <= (phase_q == PH_DONE) && flt_rsp.status;
      dist_q   <= (phase_q == PH_DONE) ? flt_rsp.distance : '0;
      vs_q     <= cnt_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.trigger       = trig_q;
  assign out_o.busy_res      = busy_q;
  assign out_o.done_res      = done_q;
  assign out_o.status        = status_q;
  assign out_o.distance      = dist_q;
  assign out_o.valid_samples = vs_q;

endmodule
